// ===== hw/rtl/mtwb_pkg.sv =====
// Shared types, constants and helpers for the multiplicity trigger window builder.
package mtwb_pkg;

    // Hit lanes per slice are fixed by the 2-bit channel field
    localparam int LANES  = 4;
    localparam int LANE_W = 2;
    localparam logic [LANE_W-1:0] LANE_MAX = 2'd3;

    // Configuration register indexes (paddr[2])
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_MULT      = 1'b1;

    typedef struct packed {
        logic signed [15:0] sample;
        logic [1:0]         channel;
        logic               slice_end;
        logic               run_end;
    } in_beat_t;

    typedef struct packed {
        logic [23:0]        event_number;
        logic [23:0]        hit_time;
        logic [1:0]         hit_channel;
        logic signed [15:0] hit_value;
        logic [5:0]         hit_total;
        logic               last_hit;
    } out_beat_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic cnt_step;   // add one slice's hits to the total
        logic advance;    // move scan position to the next lane
        logic rd_issue;   // read the sample at the scan position
        logic out_load;   // load the output register from read data
        logic finish;     // close the slice: shift history or clear the run
    } ctrl_cmd_t;

    // Datapath -> controller status
    typedef struct packed {
        logic emit;       // beat on the input closes a slice that emits a window
        logic cnt_done;   // counting at the newest slice
        logic scan_hit;   // scan position holds a hit
        logic scan_last;  // scan position is the final one
        logic out_free;   // output register can take a beat
    } dp_status_t;

    function automatic logic [2:0] popcount4(input logic [3:0] m);
        popcount4 = 3'(m[0]) + 3'(m[1]) + 3'(m[2]) + 3'(m[3]);
    endfunction

endpackage

// ===== hw/rtl/mtwb_ram.sv =====
// Generic simple dual-port RAM with registered read.
module mtwb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/mtwb_regs.sv =====
// APB configuration registers: hit threshold and multiplicity setting.
module mtwb_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output logic signed [15:0] threshold,
    output logic [2:0]         mult
);

    logic signed [15:0] threshold_reg;
    logic [2:0]         mult_reg;
    logic               wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= 16'sd12;
            mult_reg      <= 3'd2;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                mtwb_pkg::REG_THRESHOLD: threshold_reg <= pwdata[15:0];
                mtwb_pkg::REG_MULT:      mult_reg      <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (paddr[2])
            mtwb_pkg::REG_THRESHOLD: prdata = {16'b0, threshold_reg};
            mtwb_pkg::REG_MULT:      prdata = {29'b0, mult_reg};
            default:                 prdata = 32'b0;
        endcase
    end

    assign threshold = threshold_reg;
    assign mult      = mult_reg;

endmodule

// ===== hw/rtl/mtwb_ctrl.sv =====
// Controller: sequences hit counting, window scan and slice close.
module mtwb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  mtwb_pkg::dp_status_t   status,
    output mtwb_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COUNT,
        ST_SCAN,
        ST_WAIT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.emit)
                begin
                    state_next = ST_COUNT;
                end
            end
            ST_COUNT:
            begin
                cmd.cnt_step = 1'b1;
                if (status.cnt_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_hit)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_WAIT;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.advance = 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.scan_last)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/mtwb_dp.sv =====
// Datapath: slice history, trigger logic, window scan and output register.
module mtwb_dp #(
    parameter int CHANNELS    = 4,
    parameter int HALF_WINDOW = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  mtwb_pkg::in_beat_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mtwb_pkg::out_beat_t   out_data,
    input  logic signed [15:0]    threshold,
    input  logic [2:0]            mult,
    input  mtwb_pkg::ctrl_cmd_t   cmd,
    output mtwb_pkg::dp_status_t  status
);

    localparam int WS     = 2 * HALF_WINDOW + 1;
    localparam int AGE_W  = $clog2(WS);
    localparam int PEND_W = $clog2(HALF_WINDOW + 1);
    localparam int ADDR_W = AGE_W + mtwb_pkg::LANE_W;
    localparam int DEPTH  = (2 ** AGE_W) * mtwb_pkg::LANES;
    localparam logic [AGE_W-1:0]  FULL_AGE = AGE_W'(2 * HALF_WINDOW);
    localparam logic [PEND_W-1:0] HALF_P   = PEND_W'(HALF_WINDOW);

    logic [3:0]        mask_reg [WS];
    logic [3:0]        mask_next [WS];
    logic [WS-1:0]     valid_reg, valid_next;
    logic [23:0]       slice_reg, slice_next;
    logic [23:0]       event_reg, event_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [PEND_W-1:0] dead_reg, dead_next;
    logic [AGE_W-1:0]  oldest_reg, oldest_next;
    logic [AGE_W-1:0]  age_reg, age_next;
    logic [1:0]        lane_reg, lane_next;
    logic              rend_reg, rend_next;
    logic [5:0]        total_reg, total_next;
    logic [5:0]        written_reg, written_next;
    logic              out_valid_reg, out_valid_next;
    mtwb_pkg::out_beat_t out_data_reg, out_data_next;

    logic              take, lane_ok, is_hit, closing, emit_a, trig, emit;
    logic [3:0]        mask0_upd;
    logic [PEND_W-1:0] pend_new, dead_new;
    logic [23:0]       event_new;
    logic [AGE_W-1:0]  oldest_new;
    logic [AGE_W-1:0]  slot;
    logic [15:0]       rd_data;
    logic              do_shift, do_clear;
    logic [3:0]        shift_src;

    assign take = in_valid && in_ready;

    // hit update of the slice being built
    assign lane_ok = (int'(in_data.channel) < CHANNELS);
    assign is_hit  = (in_data.sample > threshold);
    always_comb
    begin
        mask0_upd = mask_reg[0];
        if (lane_ok)
        begin
            mask0_upd[in_data.channel] = is_hit;
        end
    end

    // trigger, dead time and pending countdown at slice close
    assign closing   = in_data.slice_end || in_data.run_end;
    assign emit_a    = (pend_reg == PEND_W'(1));
    assign trig      = (dead_reg == '0) && (mtwb_pkg::popcount4(mask0_upd) > mult);
    assign pend_new  = trig ? HALF_P : ((pend_reg != '0) ? pend_reg - PEND_W'(1) : '0);
    assign dead_new  = (dead_reg != '0) ? dead_reg - PEND_W'(1) : (trig ? HALF_P : '0);
    assign event_new = trig ? event_reg + 24'd1 : event_reg;
    assign emit      = closing && (emit_a || (in_data.run_end && pend_new != '0));
    assign oldest_new = emit_a ? FULL_AGE : FULL_AGE - AGE_W'(pend_new);

    // history slot of the scan position
    assign slot = slice_reg[AGE_W-1:0] - age_reg;

    mtwb_ram #(
        .WIDTH(16),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (take && lane_ok),
        .waddr(ADDR_W'({slice_reg[AGE_W-1:0], in_data.channel})),
        .wdata(in_data.sample),
        .re   (cmd.rd_issue),
        .raddr(ADDR_W'({slot, lane_reg})),
        .rdata(rd_data)
    );

    // close actions: slice shift or run clear
    always_comb
    begin
        do_shift  = 1'b0;
        do_clear  = 1'b0;
        shift_src = mask_reg[0];
        if (take && closing && !emit)
        begin
            do_clear  = in_data.run_end;
            do_shift  = !in_data.run_end;
            shift_src = mask0_upd;
        end
        else if (cmd.finish)
        begin
            do_clear = rend_reg;
            do_shift = !rend_reg;
        end
    end

    // next-state logic
    always_comb
    begin
        mask_next      = mask_reg;
        valid_next     = valid_reg;
        slice_next     = slice_reg;
        event_next     = event_reg;
        pend_next      = pend_reg;
        dead_next      = dead_reg;
        oldest_next    = oldest_reg;
        age_next       = age_reg;
        lane_next      = lane_reg;
        rend_next      = rend_reg;
        total_next     = total_reg;
        written_next   = written_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (take)
        begin
            mask_next[0] = mask0_upd;
            if (closing)
            begin
                valid_next[0] = 1'b1;
                pend_next     = pend_new;
                dead_next     = dead_new;
                event_next    = event_new;
            end
            if (emit)
            begin
                oldest_next = oldest_new;
                age_next    = oldest_new;
                total_next  = '0;
                rend_next   = in_data.run_end;
            end
        end

        // closed slice moves to age 1, the new slice starts not yet valid
        if (do_shift)
        begin
            for (int k = WS - 1; k > 0; k--)
            begin
                mask_next[k] = (k == 1) ? shift_src : mask_reg[k-1];
            end
            mask_next[0] = '0;
            valid_next   = {valid_reg[WS-2:1], 1'b1, 1'b0};
            slice_next   = slice_reg + 24'd1;
        end
        if (do_clear)
        begin
            for (int k = 0; k < WS; k++)
            begin
                mask_next[k] = '0;
            end
            valid_next = '0;
            slice_next = '0;
            event_next = '0;
            pend_next  = '0;
            dead_next  = '0;
        end

        // total hit count, oldest slice first
        if (cmd.cnt_step)
        begin
            total_next = total_reg + (valid_reg[age_reg] ?
                         6'(mtwb_pkg::popcount4(mask_reg[age_reg])) : 6'd0);
            if (age_reg == '0)
            begin
                age_next     = oldest_reg;
                lane_next    = '0;
                written_next = '0;
            end
            else
            begin
                age_next = age_reg - AGE_W'(1);
            end
        end

        // output beat
        if (cmd.out_load)
        begin
            out_valid_next              = 1'b1;
            out_data_next.event_number  = event_reg;
            out_data_next.hit_time      = slice_reg - 24'(age_reg);
            out_data_next.hit_channel   = lane_reg;
            out_data_next.hit_value     = rd_data;
            out_data_next.hit_total     = total_reg;
            out_data_next.last_hit      = (written_reg + 6'd1 == total_reg);
            written_next                = written_reg + 6'd1;
        end

        // scan position
        if (cmd.advance)
        begin
            if (lane_reg == mtwb_pkg::LANE_MAX)
            begin
                lane_next = '0;
                age_next  = age_reg - AGE_W'(1);
            end
            else
            begin
                lane_next = lane_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WS; k++)
            begin
                mask_reg[k] <= '0;
            end
            valid_reg     <= '0;
            slice_reg     <= '0;
            event_reg     <= '0;
            pend_reg      <= '0;
            dead_reg      <= '0;
            oldest_reg    <= '0;
            age_reg       <= '0;
            lane_reg      <= '0;
            rend_reg      <= 1'b0;
            total_reg     <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            valid_reg     <= valid_next;
            slice_reg     <= slice_next;
            event_reg     <= event_next;
            pend_reg      <= pend_next;
            dead_reg      <= dead_next;
            oldest_reg    <= oldest_next;
            age_reg       <= age_next;
            lane_reg      <= lane_next;
            rend_reg      <= rend_next;
            total_reg     <= total_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign status.emit      = emit;
    assign status.cnt_done  = (age_reg == '0);
    assign status.scan_hit  = valid_reg[age_reg] && mask_reg[age_reg][lane_reg];
    assign status.scan_last = (age_reg == '0) && (lane_reg == mtwb_pkg::LANE_MAX);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/multiplicity_trigger_window_builder_top.sv =====
// Top level of the multiplicity trigger window builder.
// A beat that does not emit a window is accepted without stalling the input.
// A beat that emits a window of W slices (W up to 2*HALF_WINDOW+1) holds the
// input while its hits are counted, each lane scanned, each hit loaded and the slice closed.
// The scan reads the sample RAM at hits only; hits leave via an output register when it is free.
// Reset (rst_n low, asynchronous) clears history, counters and registers to defaults.
module multiplicity_trigger_window_builder_top #(
    parameter int CHANNELS    = 4,
    parameter int HALF_WINDOW = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mtwb_pkg::in_beat_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mtwb_pkg::out_beat_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    logic signed [15:0]   threshold;
    logic [2:0]           mult;
    mtwb_pkg::ctrl_cmd_t  cmd;
    mtwb_pkg::dp_status_t status;

    mtwb_regs u_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .threshold(threshold),
        .mult     (mult)
    );

    mtwb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mtwb_dp #(
        .CHANNELS   (CHANNELS),
        .HALF_WINDOW(HALF_WINDOW)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .threshold(threshold),
        .mult     (mult),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

// ===== hw/rtl/mtwb_checker.sv =====
// Port-level assertions for the window builder, bound to the top level.
module mtwb_checker #(
    parameter int CHANNELS = 4
) (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input mtwb_pkg::in_beat_t  in_data,
    input logic                out_valid,
    input logic                out_ready,
    input mtwb_pkg::out_beat_t out_data,
    input logic                pready
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat changed while stalled");

    // every hit record belongs to a numbered event with a nonzero total
    a_out_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.hit_total != 6'd0) && (out_data.event_number != 24'd0)
                      && (int'(out_data.hit_channel) < CHANNELS))
        else $error("hit record with zero total, event or bad channel");

    // a beat that closes no slice never stalls the input
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_data.slice_end && !in_data.run_end |=> in_ready)
        else $error("input stalled after a non-closing beat");

    // the configuration port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind multiplicity_trigger_window_builder_top mtwb_checker #(.CHANNELS(CHANNELS)) u_chk (.*);

// ===== test/multiplicity_trigger_window_builder_top_tb.sv =====
// Testbench for the multiplicity trigger window builder: predicted hit records checked per beat.
`timescale 1ns / 1ps

module multiplicity_trigger_window_builder_top_tb;

    localparam int HALF_W  = 5;
    localparam int SLICES  = 2 * HALF_W + 1;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    mtwb_pkg::in_beat_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    mtwb_pkg::out_beat_t out_data;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    multiplicity_trigger_window_builder_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor state: a copy of the trigger and window history
    logic signed [15:0] thr_q;
    logic [2:0]         mult_q;
    logic [15:0]        hist_q [SLICES][4];
    logic [3:0]         mask_q [SLICES];
    logic [SLICES-1:0]  valid_q;
    logic [23:0]        slice_cnt_q;
    logic [2:0]         dead_q;
    logic [3:0]         pend_q;
    logic [23:0]        event_cnt_q;

    mtwb_pkg::out_beat_t hit_records_q [$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int idle_cycles = 0;

    task automatic clear_run();
        for (int s = 0; s < SLICES; s++)
        begin
            mask_q[s] = '0;
            for (int c = 0; c < 4; c++)
                hist_q[s][c] = '0;
        end
        valid_q = '0;
        slice_cnt_q = '0;
        dead_q = '0;
        pend_q = '0;
        event_cnt_q = '0;
    endtask

    function automatic int count_hits(logic [3:0] m);
        return int'(m[0]) + int'(m[1]) + int'(m[2]) + int'(m[3]);
    endfunction

    // Queue every hit from age 'oldest' down to the newest slice
    task automatic queue_window(int oldest);
        int total;
        int written;
        int a;
        mtwb_pkg::out_beat_t r;
        total = 0;
        written = 0;
        for (int k = 0; k <= oldest; k++)
            if (valid_q[k])
                total += count_hits(mask_q[k]);
        for (int i = 0; i <= oldest; i++)
        begin
            a = oldest - i;
            if (!valid_q[a])
                continue;
            for (int c = 0; c < 4; c++)
            begin
                if (!mask_q[a][c])
                    continue;
                written++;
                r.event_number = event_cnt_q;
                r.hit_time = slice_cnt_q - 24'(a);
                r.hit_channel = 2'(c);
                r.hit_value = hist_q[a][c];
                r.hit_total = 6'(total);
                r.last_hit = (written == total);
                hit_records_q = {hit_records_q, r};
            end
        end
    endtask

    task automatic predict_beat(mtwb_pkg::in_beat_t b);
        hist_q[0][b.channel] = b.sample;
        mask_q[0][b.channel] = (b.sample > thr_q);
        if (!(b.slice_end || b.run_end))
            return;
        valid_q[0] = 1'b1;
        if (pend_q != 0)
        begin
            pend_q--;
            if (pend_q == 0)
                queue_window(2 * HALF_W);
        end
        if (dead_q != 0)
            dead_q--;
        else if (count_hits(mask_q[0]) > int'(mult_q))
        begin
            event_cnt_q++;
            pend_q = 4'(HALF_W);
            dead_q = 3'(HALF_W);
        end
        if (b.run_end)
        begin
            if (pend_q != 0)
                queue_window(2 * HALF_W - int'(pend_q));
            clear_run();
            return;
        end
        for (int s = SLICES - 1; s > 0; s--)
        begin
            mask_q[s] = mask_q[s-1];
            hist_q[s] = hist_q[s-1];
        end
        mask_q[0] = '0;
        for (int c = 0; c < 4; c++)
            hist_q[0][c] = '0;
        valid_q = valid_q << 1;
        slice_cnt_q++;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // Result side: random stall and field-by-field compare
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (hit_records_q.size() == 0)
                    report_mismatch("unexpected beat", 32'(out_data.hit_time), 32'd0);
                else
                begin
                    mtwb_pkg::out_beat_t w;
                    w = hit_records_q.pop_front();
                    if (out_data.event_number !== w.event_number)
                        report_mismatch("event_number", 32'(out_data.event_number),
                                        32'(w.event_number));
                    if (out_data.hit_time !== w.hit_time)
                        report_mismatch("hit_time", 32'(out_data.hit_time), 32'(w.hit_time));
                    if (out_data.hit_channel !== w.hit_channel)
                        report_mismatch("hit_channel", 32'(out_data.hit_channel),
                                        32'(w.hit_channel));
                    if (out_data.hit_value !== w.hit_value)
                        report_mismatch("hit_value", 32'(out_data.hit_value), 32'(w.hit_value));
                    if (out_data.hit_total !== w.hit_total)
                        report_mismatch("hit_total", 32'(out_data.hit_total), 32'(w.hit_total));
                    if (out_data.last_hit !== w.last_hit)
                        report_mismatch("last_hit", 32'(out_data.last_hit), 32'(w.last_hit));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no accepted beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("multiplicity_trigger_window_builder_top_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == mtwb_pkg::REG_THRESHOLD)
            thr_q = value[15:0];
        else
            mult_q = value[2:0];
    endtask

    // Send one beat; the predictor runs as it is accepted. Valid stays up
    // afterwards until the next idle gap or an explicit idle.
    task automatic send_beat(mtwb_pkg::in_beat_t b);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_beat(b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (hit_records_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic mtwb_pkg::in_beat_t make_beat(logic [15:0] s, logic [1:0] c,
                                                     logic se, logic re);
        mtwb_pkg::in_beat_t b;
        b.sample = s;
        b.channel = c;
        b.slice_end = se;
        b.run_end = re;
        return b;
    endfunction

    // A slice of four channels with about 'hot' of them above threshold
    task automatic send_slice(int hot, logic re);
        logic [15:0] s;
        logic se;
        int order;
        order = $urandom_range(1);
        for (int c = 0; c < 4; c++)
        begin
            if ($urandom_range(3) < hot)
                s = 16'($signed(thr_q) + $signed(17'($urandom_range(30000, 1))));
            else
                s = 16'($urandom);
            if (s == 16'h8000 && $urandom_range(1))
                s = 16'h7fff;
            se = (c == 3);
            send_beat(make_beat(s, order ? 2'(c) : 2'(3 - c), se, se && re));
        end
    endtask

    typedef struct {
        mtwb_pkg::in_beat_t beat;
    } stim_row_t;

    stim_row_t directed [] = '{
        '{'{16'h7fff, 2'd0, 1'b0, 1'b0}},
        '{'{16'h7fff, 2'd1, 1'b0, 1'b0}},
        '{'{16'h8000, 2'd2, 1'b0, 1'b0}},
        '{'{16'h000c, 2'd3, 1'b1, 1'b0}},
        '{'{16'h1000, 2'd0, 1'b0, 1'b0}},
        '{'{16'h2000, 2'd1, 1'b0, 1'b0}},
        '{'{16'h3000, 2'd2, 1'b0, 1'b0}},
        '{'{16'h000d, 2'd3, 1'b1, 1'b0}},
        '{'{16'h0100, 2'd0, 1'b0, 1'b0}},
        '{'{16'h0001, 2'd0, 1'b0, 1'b0}},
        '{'{16'h5555, 2'd2, 1'b1, 1'b0}},
        '{'{16'h0000, 2'd1, 1'b1, 1'b0}},
        '{'{16'haaaa, 2'd3, 1'b0, 1'b0}},
        '{'{16'h4000, 2'd1, 1'b0, 1'b1}},
        '{'{16'h7000, 2'd0, 1'b0, 1'b0}},
        '{'{16'h7000, 2'd1, 1'b0, 1'b0}},
        '{'{16'h7000, 2'd2, 1'b0, 1'b0}},
        '{'{16'h7000, 2'd3, 1'b1, 1'b1}}
    };

    initial
    begin
        thr_q = 16'sd12;
        mult_q = 3'd2;
        clear_run();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows at reset settings: extremes, replaced channel, run end
        foreach (directed[i])
            send_beat(directed[i].beat);
        drain();

        // Random phases over several register settings, extremes included
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin write_reg(mtwb_pkg::REG_THRESHOLD, 32'h0000_8000);
                         write_reg(mtwb_pkg::REG_MULT, 32'd0); end
                1: begin write_reg(mtwb_pkg::REG_THRESHOLD, 32'h0000_7fff);
                         write_reg(mtwb_pkg::REG_MULT, 32'd4); end
                2: begin write_reg(mtwb_pkg::REG_THRESHOLD, 32'h0000_0800);
                         write_reg(mtwb_pkg::REG_MULT, 32'd1); end
                3: begin write_reg(mtwb_pkg::REG_THRESHOLD, 32'h0000_ff00);
                         write_reg(mtwb_pkg::REG_MULT, 32'd3); end
                4: begin write_reg(mtwb_pkg::REG_THRESHOLD, 32'h0000_0000);
                         write_reg(mtwb_pkg::REG_MULT, 32'd7); end
                default: begin write_reg(mtwb_pkg::REG_THRESHOLD, 32'h0000_2000);
                               write_reg(mtwb_pkg::REG_MULT, 32'd2); end
            endcase
            send_idle_pct = (phase < 2) ? 18 : (phase < 4) ? 50 : 0;
            recv_idle_pct = (phase < 2) ? 50 : (phase < 4) ? 18 : 0;
            for (int n = 0; n < 21; n++)
            begin
                if ($urandom_range(9) < 8)
                    send_slice($urandom_range(4), ($urandom_range(11) == 0));
                else
                    send_beat(make_beat(16'($urandom), 2'($urandom),
                                        1'($urandom), ($urandom_range(5) == 0)));
                // sender holds off until all hit records are out
                if (n == 9)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (hit_records_q.size() != 0)
                        @(posedge clk);
                end
            end
            send_beat(make_beat(16'($urandom), 2'($urandom), 1'b0, 1'b1));
            drain();
        end

        if (errors == 0 && hit_records_q.size() == 0)
            $display("multiplicity_trigger_window_builder_top_tb: PASS");
        else
            $display("multiplicity_trigger_window_builder_top_tb: FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/mtwb_pkg.sv
hw/rtl/mtwb_ram.sv
hw/rtl/mtwb_regs.sv
hw/rtl/mtwb_ctrl.sv
hw/rtl/mtwb_dp.sv
hw/rtl/multiplicity_trigger_window_builder_top.sv
hw/rtl/mtwb_checker.sv
test/multiplicity_trigger_window_builder_top_tb.sv
